[design/aes_pkg.sv]
// shared types and constants for the adjacency edge store
package aes_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 1024;
    localparam int KEY_BITS     = 32;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = VIDX_W + 1;
    localparam int EIDX_W       = $clog2(MAX_EDGES);
    localparam int LINK_W       = EIDX_W + 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_EDGES);

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SELF      = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_VFULL     = 3'd4,
        ST_PFULL     = 3'd5,
        ST_SKIPPED   = 3'd6
    } status_t;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_DEL = 1'b1
    } opcode_t;

endpackage

[design/adjacency_edge_store.sv]
// adjacency edge store: vertex table, edge pool and free stack in block memories
//
//  channel  | ports                      | transaction
//  ---------+----------------------------+--------------------------------------------
//  input    | s_tvalid s_tready s_tdata  | one add or delete command (opcode in s_tuser)
//  result   | m_tvalid m_tready m_tdata  | one status word per command
//
// one command at a time: accept it, read and compare the vertex entries for each key
// and, on an add, enter a key missing from the table, then per direction fetch the list
// head, read and compare the list entries and close (end of list, free slot pop, insert
// or remove), and post the result; each memory has a single read port.
// a vertex-full reject skips the list part; a self loop on an add or a missing vertex
// is rejected by the check before the list part instead.
// reset clears vertex count, free stack top and pool high water; memories
// keep no reset and are only read where written before.
// the next command is taken while a result waits; it stalls in its result cycle
// until m_tready frees the output register.
module adjacency_edge_store (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // source_key[31:0], target_key[63:32], edge_weight[95:64], both_ways[96]
    input  logic [aes_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], forward_status[3:1], reverse_status[6:4], source_index[14:7],
    // target_index[22:15]
    output logic [aes_pkg::M_TDATA_W-1:0] m_tdata
);
    import aes_pkg::*;

    typedef enum logic [3:0] {
        IDLE, VS_RD, VS_CMP, ES_START, ES_HEAD, ES_RD, ES_CMP,
        ALLOC_RD, INSERT, REMOVE, DONE
    } state_t;

    state_t state_reg, state_next;

    // memories
    logic [KEY_BITS-1:0] vkeys_mem [MAX_VERTICES];
    logic [LINK_W-1:0]   head_mem  [MAX_VERTICES];
    logic [VIDX_W-1:0]   etgt_mem  [MAX_EDGES];
    logic [LINK_W-1:0]   elink_mem [MAX_EDGES];
    logic [EIDX_W-1:0]   free_mem  [MAX_EDGES];

    logic [KEY_BITS-1:0] vk_q;
    logic [LINK_W-1:0]   head_q, elink_q;
    logic [VIDX_W-1:0]   etgt_q;
    logic [EIDX_W-1:0]   free_q;

    // port controls
    logic                vk_we, vk_re;
    logic [VIDX_W-1:0]   vk_addr;
    logic                hd_we, hd_re;
    logic [VIDX_W-1:0]   hd_addr;
    logic [LINK_W-1:0]   hd_wdata;
    logic                el_we, el_re, et_we;
    logic [EIDX_W-1:0]   el_waddr, el_raddr;
    logic [LINK_W-1:0]   el_wdata;
    logic                fs_we, fs_re;
    logic [EIDX_W-1:0]   fs_addr;

    // command and working registers
    logic                op_reg, op_next;
    logic [KEY_BITS-1:0] skey_reg, skey_next, tkey_reg, tkey_next;
    logic                both_reg, both_next;
    logic [VIDX_W-1:0]   si_reg, si_next, ti_reg, ti_next;
    logic                si_ok_reg, si_ok_next, ti_ok_reg, ti_ok_next;
    logic                vsel_reg, vsel_next;
    logic [VCNT_W-1:0]   vidx_reg, vidx_next;
    logic [VCNT_W-1:0]   vcount_reg, vcount_next;
    logic [LINK_W-1:0]   ftop_reg, ftop_next, hw_reg, hw_next;
    logic [VIDX_W-1:0]   from_reg, from_next, to_reg, to_next;
    logic [LINK_W-1:0]   cur_reg, cur_next, prev_reg, prev_next, head_reg, head_next;
    logic [EIDX_W-1:0]   slot_reg, slot_next;
    logic                phase_reg, phase_next;
    status_t             fst_reg, fst_next, rst_reg, rst_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [KEY_BITS-1:0] key_sel;
    logic                dir_done;
    status_t             dir_status;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign key_sel  = vsel_reg ? tkey_reg : skey_reg;

    // memory arrays
    always_ff @(posedge aclk) begin
        if (vk_we) vkeys_mem[vk_addr] <= key_sel;
        if (vk_re) vk_q <= vkeys_mem[vk_addr];
        if (hd_we) head_mem[hd_addr] <= hd_wdata;
        if (hd_re) head_q <= head_mem[hd_addr];
        if (et_we) etgt_mem[el_waddr] <= to_reg;
        if (el_we) elink_mem[el_waddr] <= el_wdata;
        if (el_re) begin
            etgt_q  <= etgt_mem[el_raddr];
            elink_q <= elink_mem[el_raddr];
        end
        if (fs_we) free_mem[fs_addr] <= cur_reg[EIDX_W-1:0];
        if (fs_re) free_q <= free_mem[fs_addr];
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        skey_next     = skey_reg;
        tkey_next     = tkey_reg;
        both_next     = both_reg;
        si_next       = si_reg;
        ti_next       = ti_reg;
        si_ok_next    = si_ok_reg;
        ti_ok_next    = ti_ok_reg;
        vsel_next     = vsel_reg;
        vidx_next     = vidx_reg;
        vcount_next   = vcount_reg;
        ftop_next     = ftop_reg;
        hw_next       = hw_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        head_next     = head_reg;
        slot_next     = slot_reg;
        phase_next    = phase_reg;
        fst_next      = fst_reg;
        rst_next      = rst_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        vk_we = 1'b0; vk_re = 1'b0; vk_addr = vidx_reg[VIDX_W-1:0];
        hd_we = 1'b0; hd_re = 1'b0; hd_addr = from_reg; hd_wdata = LINK_NULL;
        el_we = 1'b0; et_we = 1'b0; el_re = 1'b0;
        el_waddr = slot_reg; el_raddr = cur_reg[EIDX_W-1:0]; el_wdata = head_reg;
        fs_we = 1'b0; fs_re = 1'b0; fs_addr = ftop_reg[EIDX_W-1:0];
        dir_done = 1'b0; dir_status = ST_OK;

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    skey_next  = s_tdata[31:0];
                    tkey_next  = s_tdata[63:32];
                    both_next  = s_tdata[96];
                    si_next    = '0;
                    ti_next    = '0;
                    si_ok_next = 1'b0;
                    ti_ok_next = 1'b0;
                    vsel_next  = 1'b0;
                    vidx_next  = '0;
                    phase_next = 1'b0;
                    rst_next   = ST_SKIPPED;
                    state_next = VS_RD;
                end
            end
            VS_RD: begin
                if (vidx_reg == vcount_reg) begin
                    // key not in the table
                    if (op_reg == OP_ADD) begin
                        if (vcount_reg[VIDX_W] == 1'b0) begin
                            vk_we       = 1'b1;
                            hd_we       = 1'b1;
                            hd_addr     = vcount_reg[VIDX_W-1:0];
                            vcount_next = vcount_reg + 1'b1;
                            if (vsel_reg) begin
                                ti_next = vcount_reg[VIDX_W-1:0];
                                ti_ok_next = 1'b1;
                            end else begin
                                si_next = vcount_reg[VIDX_W-1:0];
                                si_ok_next = 1'b1;
                            end
                        end
                    end
                    vidx_next = '0;
                    vsel_next = 1'b1;
                    if (op_reg == OP_ADD && vcount_reg[VIDX_W]) begin
                        fst_next   = ST_VFULL;
                        state_next = DONE;
                    end else if (vsel_reg) begin
                        state_next = ES_START;
                    end
                end else begin
                    vk_re      = 1'b1;
                    state_next = VS_CMP;
                end
            end
            VS_CMP: begin
                if (vk_q == key_sel) begin
                    if (vsel_reg) begin
                        ti_next = vidx_reg[VIDX_W-1:0];
                        ti_ok_next = 1'b1;
                    end else begin
                        si_next = vidx_reg[VIDX_W-1:0];
                        si_ok_next = 1'b1;
                    end
                    vidx_next  = '0;
                    vsel_next  = 1'b1;
                    state_next = vsel_reg ? ES_START : VS_RD;
                end else begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = VS_RD;
                end
            end
            ES_START: begin
                // entry to the forward pass checks vertex outcome
                if (!phase_reg && !(si_ok_reg && ti_ok_reg)) begin
                    fst_next   = ST_NOT_FOUND;
                    state_next = DONE;
                end else if (!phase_reg && op_reg == OP_ADD && si_reg == ti_reg) begin
                    fst_next   = ST_SELF;
                    state_next = DONE;
                end else begin
                    if (!phase_reg) begin
                        from_next = si_reg;
                        to_next   = ti_reg;
                        hd_addr   = si_reg;
                    end
                    hd_re      = 1'b1;
                    state_next = ES_HEAD;
                end
            end
            ES_HEAD: begin
                cur_next   = head_q;
                head_next  = head_q;
                prev_next  = LINK_NULL;
                state_next = ES_RD;
            end
            ES_RD: begin
                if (cur_reg[EIDX_W]) begin
                    // end of list, no match
                    if (op_reg == OP_DEL) begin
                        dir_done = 1'b1; dir_status = ST_NOT_FOUND;
                    end else if (ftop_reg != '0) begin
                        fs_re      = 1'b1;
                        fs_addr    = EIDX_W'(ftop_reg - 1'b1);
                        ftop_next  = ftop_reg - 1'b1;
                        state_next = ALLOC_RD;
                    end else if (!hw_reg[EIDX_W]) begin
                        slot_next  = hw_reg[EIDX_W-1:0];
                        hw_next    = hw_reg + 1'b1;
                        state_next = INSERT;
                    end else begin
                        dir_done = 1'b1; dir_status = ST_PFULL;
                    end
                end else begin
                    el_re      = 1'b1;
                    state_next = ES_CMP;
                end
            end
            ES_CMP: begin
                if (etgt_q == to_reg) begin
                    if (op_reg == OP_ADD) begin
                        dir_done = 1'b1; dir_status = ST_EXISTS;
                    end else begin
                        state_next = REMOVE;
                    end
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = elink_q;
                    state_next = ES_RD;
                end
            end
            ALLOC_RD: begin
                slot_next  = free_q;
                state_next = INSERT;
            end
            INSERT: begin
                et_we    = 1'b1;
                el_we    = 1'b1;
                hd_we    = 1'b1;
                hd_wdata = {1'b0, slot_reg};
                dir_done = 1'b1; dir_status = ST_OK;
            end
            REMOVE: begin
                // unlink and push the slot on the free stack
                if (prev_reg[EIDX_W]) begin
                    hd_we    = 1'b1;
                    hd_wdata = elink_q;
                end else begin
                    el_we    = 1'b1;
                    el_waddr = prev_reg[EIDX_W-1:0];
                    el_wdata = elink_q;
                end
                if (ftop_reg[EIDX_W] == 1'b0) begin
                    fs_we     = 1'b1;
                    ftop_next = ftop_reg + 1'b1;
                end
                dir_done = 1'b1; dir_status = ST_OK;
            end
            DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, ti_reg, si_reg, rst_reg, fst_reg,
                                     (fst_reg == ST_OK) || (rst_reg == ST_OK)};
                    state_next    = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase

        // close one direction, start the reverse one when asked
        if (dir_done) begin
            if (!phase_reg) begin
                fst_next = dir_status;
                if (both_reg) begin
                    phase_next = 1'b1;
                    from_next  = to_reg;
                    to_next    = from_reg;
                    state_next = ES_START;
                end else begin
                    state_next = DONE;
                end
            end else begin
                rst_next   = dir_status;
                state_next = DONE;
            end
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            vcount_reg   <= '0;
            ftop_reg     <= '0;
            hw_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            ftop_reg     <= ftop_next;
            hw_reg       <= hw_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        skey_reg    <= skey_next;
        tkey_reg    <= tkey_next;
        both_reg    <= both_next;
        si_reg      <= si_next;
        ti_reg      <= ti_next;
        si_ok_reg   <= si_ok_next;
        ti_ok_reg   <= ti_ok_next;
        vsel_reg    <= vsel_next;
        vidx_reg    <= vidx_next;
        from_reg    <= from_next;
        to_reg      <= to_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        head_reg    <= head_next;
        slot_reg    <= slot_next;
        phase_reg   <= phase_next;
        fst_reg     <= fst_next;
        rst_reg     <= rst_next;
        m_tdata_reg <= m_tdata_next;
    end

    // checks
    a_free_le_hw: assert property (@(posedge aclk) disable iff (!aresetn)
        ftop_reg <= hw_reg) else $error("free stack deeper than slots handed out");
    a_vcount_max: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg <= VCNT_W'(MAX_VERTICES)) else $error("vertex count overflow");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second command taken while busy");

endmodule
